// File: sv/sfrag_pkg.sv
// sfrag_pkg: constants, record types and width helpers for the sequence fragmenter
// no dependencies; every other file of the block but sfrag_if imports this package
package sfrag_pkg;

    localparam int POS_BITS   = 32;
    localparam int CMP_BITS   = (POS_BITS > 32) ? POS_BITS : 32;
    localparam int CFG_BITS   = 32;
    localparam int LIMIT_BITS = 16;
    localparam int IDX_BITS   = 2;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_BITS   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [IDX_BITS-1:0] {
        REG_PIECE_LENGTH   = 2'd0,
        REG_OVERLAP_LENGTH = 2'd1,
        REG_N_RUN_LIMIT    = 2'd2
    } reg_index_t;

    localparam logic [7:0] CHAR_N_UPPER = 8'h4E;
    localparam logic [7:0] CHAR_N_LOWER = 8'h6E;

    localparam logic [CFG_BITS-1:0]   PIECE_RESET   = 32'd1024;
    localparam logic [CFG_BITS-1:0]   OVERLAP_RESET = 32'd0;
    localparam logic [LIMIT_BITS-1:0] LIMIT_RESET   = 16'd50;
    localparam logic [LIMIT_BITS-1:0] LIMIT_MAX     = 16'hFFFF;

    localparam logic [POS_BITS-1:0] POS_ZERO = '0;
    localparam logic [POS_BITS-1:0] POS_ONE  = {{(POS_BITS-1){1'b0}}, 1'b1};

    // one region as the front hands it over: raw start, exclusive stop, abut flag
    typedef struct packed {
        logic [POS_BITS-1:0] start_pos;
        logic [POS_BITS-1:0] stop_pos;
        logic                abut;
    } region_t;

    // regions caused by one input word: one or two
    typedef struct packed {
        logic    two;
        region_t first;
        region_t second;
    } q_entry_t;

    function automatic logic [CMP_BITS-1:0] pos_wide(input logic [POS_BITS-1:0] p);
        logic [CMP_BITS+POS_BITS-1:0] t;
        t = {{CMP_BITS{1'b0}}, p};
        return t[CMP_BITS-1:0];
    endfunction

    function automatic logic [CMP_BITS-1:0] cfg_wide(input logic [CFG_BITS-1:0] v);
        logic [CMP_BITS+CFG_BITS-1:0] t;
        t = {{CMP_BITS{1'b0}}, v};
        return t[CMP_BITS-1:0];
    endfunction

    function automatic logic [31:0] wide_to_out(input logic [CMP_BITS-1:0] v);
        logic [CMP_BITS+31:0] t;
        t = {32'd0, v};
        return t[31:0];
    endfunction

endpackage

// File: sv/sfrag_if.sv
// sfrag_if: valid/ready channel interfaces for base words and region words
// self-contained; plain fixed-width payloads, no package needed

interface sfrag_base_if;
    logic       valid;
    logic       ready;
    logic [7:0] base_char;
    logic       last_base;

    modport source (output valid, base_char, last_base, input ready);
    modport sink   (input valid, base_char, last_base, output ready);
endinterface

interface sfrag_region_if;
    logic        valid;
    logic        ready;
    logic [31:0] region_start;
    logic [31:0] region_end;
    logic [31:0] fragment_number;
    logic        final_of_item;

    modport source (output valid, region_start, region_end, fragment_number,
                    final_of_item, input ready);
    modport sink   (input valid, region_start, region_end, fragment_number,
                    final_of_item, output ready);
endinterface

// File: sv/sfrag_front.sv
// sfrag_front: per-base scan state; classifies each base word and forms region records
// depends on sfrag_pkg and sfrag_if; feeds sfrag_queue
module sfrag_front
    import sfrag_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    sfrag_base_if.sink            bases,
    input  logic [CFG_BITS-1:0]   piece_length,
    input  logic [LIMIT_BITS-1:0] n_run_limit,
    output logic                  push_valid,
    input  logic                  push_ready,
    output q_entry_t              push_entry
);

    logic                  in_region_reg, in_region_next;
    logic [POS_BITS-1:0]   position_reg, position_next;
    logic [POS_BITS-1:0]   open_start_reg, open_start_next;
    logic [POS_BITS-1:0]   last_good_reg, last_good_next;
    logic [LIMIT_BITS-1:0] n_run_reg, n_run_next;
    logic [POS_BITS-1:0]   prev_end_reg, prev_end_next;
    logic                  have_prev_reg, have_prev_next;

    logic                  is_n;
    logic                  fire;
    logic [CFG_BITS-1:0]   len;
    logic [LIMIT_BITS-1:0] lim;
    logic [POS_BITS-1:0]   span;
    logic [POS_BITS-1:0]   pos_inc;
    logic                  emit_full, emit_nrun, emit_tail;
    logic                  open_new, region_mid;
    logic [POS_BITS-1:0]   start_mid;
    region_t               rec_full, rec_nrun, rec_tail;
    logic                  has_result;

    assign is_n    = (bases.base_char == CHAR_N_UPPER) || (bases.base_char == CHAR_N_LOWER);
    assign len     = (piece_length == '0) ? {{(CFG_BITS-1){1'b0}}, 1'b1} : piece_length;
    assign lim     = (n_run_limit == '0) ? {{(LIMIT_BITS-1){1'b0}}, 1'b1} : n_run_limit;
    assign span    = position_reg - open_start_reg;
    assign pos_inc = position_reg + POS_ONE;
    assign fire    = bases.valid && push_ready;

    always_comb
    begin
        in_region_next = in_region_reg;
        position_next  = position_reg;
        open_start_next = open_start_reg;
        last_good_next = last_good_reg;
        n_run_next     = n_run_reg;
        prev_end_next  = prev_end_reg;
        have_prev_next = have_prev_reg;
        emit_nrun      = 1'b0;
        emit_tail      = 1'b0;

        // full-length region closed with this base as lookahead
        emit_full = in_region_reg && (pos_wide(span) >= cfg_wide(len));
        rec_full.start_pos = open_start_reg;
        rec_full.stop_pos  = is_n ? last_good_reg : position_reg;
        rec_full.abut      = have_prev_reg && (prev_end_reg == open_start_reg);

        region_mid = emit_full ? 1'b0 : in_region_reg;
        open_new   = !region_mid && !is_n;
        start_mid  = open_new ? position_reg : open_start_reg;
        if (open_new)
        begin
            n_run_next = '0;
        end
        region_mid = region_mid || open_new;
        open_start_next = start_mid;

        if (region_mid)
        begin
            if (is_n)
            begin
                if (n_run_next != LIMIT_MAX)
                begin
                    n_run_next = n_run_next + {{(LIMIT_BITS-1){1'b0}}, 1'b1};
                end
                if (n_run_next >= lim)
                begin
                    emit_nrun  = 1'b1;
                    region_mid = 1'b0;
                end
            end
            else
            begin
                n_run_next     = '0;
                last_good_next = pos_inc;
            end
        end

        // n-run cut never follows a full close, so its abut test uses the old end
        rec_nrun.start_pos = start_mid;
        rec_nrun.stop_pos  = last_good_reg;
        rec_nrun.abut      = have_prev_reg && (prev_end_reg == start_mid);

        emit_tail = bases.last_base && region_mid;
        rec_tail.start_pos = start_mid;
        rec_tail.stop_pos  = pos_inc;
        rec_tail.abut      = emit_full ||
                             (have_prev_reg && (prev_end_reg == start_mid));

        in_region_next = region_mid;
        if (emit_full)
        begin
            prev_end_next  = rec_full.stop_pos;
            have_prev_next = 1'b1;
        end
        if (emit_nrun)
        begin
            prev_end_next  = rec_nrun.stop_pos;
            have_prev_next = 1'b1;
        end

        if (bases.last_base)
        begin
            in_region_next = 1'b0;
            position_next  = POS_ZERO;
            n_run_next     = '0;
            have_prev_next = 1'b0;
            prev_end_next  = POS_ZERO;
        end
        else
        begin
            position_next = pos_inc;
        end

        has_result = emit_full || emit_nrun || emit_tail;
        push_entry.two    = emit_full && emit_tail;
        push_entry.first  = emit_full ? rec_full : (emit_nrun ? rec_nrun : rec_tail);
        push_entry.second = rec_tail;
    end

    assign push_valid  = bases.valid && has_result;
    assign bases.ready = push_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_region_reg  <= 1'b0;
            position_reg   <= POS_ZERO;
            open_start_reg <= POS_ZERO;
            last_good_reg  <= POS_ZERO;
            n_run_reg      <= '0;
            prev_end_reg   <= POS_ZERO;
            have_prev_reg  <= 1'b0;
        end
        else if (fire)
        begin
            in_region_reg  <= in_region_next;
            position_reg   <= position_next;
            open_start_reg <= open_start_next;
            last_good_reg  <= last_good_next;
            n_run_reg      <= n_run_next;
            prev_end_reg   <= prev_end_next;
            have_prev_reg  <= have_prev_next;
        end
    end

endmodule

// File: sv/sfrag_queue.sv
// sfrag_queue: short register queue of region entries between front and back
// depends on sfrag_pkg
module sfrag_queue
    import sfrag_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     push_valid,
    output logic     push_ready,
    input  q_entry_t push_entry,
    output logic     pop_valid,
    input  logic     pop_ready,
    output q_entry_t pop_entry
);

    q_entry_t               slot_reg [QUEUE_DEPTH];
    logic [QPTR_BITS-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [QCNT_BITS-1:0]   count_reg;
    logic                   do_push, do_pop;

    localparam logic [QPTR_BITS-1:0] PTR_LAST = QPTR_BITS'(QUEUE_DEPTH - 1);
    localparam logic [QCNT_BITS-1:0] CNT_FULL = QCNT_BITS'(QUEUE_DEPTH);

    assign push_ready = (count_reg != CNT_FULL);
    assign pop_valid  = (count_reg != '0);
    assign pop_entry  = slot_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

// File: sv/sfrag_back.sv
// sfrag_back: unpacks queue entries into region words, applies overlap, numbers fragments
// depends on sfrag_pkg and sfrag_if; drains sfrag_queue
module sfrag_back
    import sfrag_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                pop_valid,
    output logic                pop_ready,
    input  q_entry_t            pop_entry,
    input  logic [CFG_BITS-1:0] overlap_length,
    sfrag_region_if.source      regions
);

    logic          out_valid_reg;
    logic [31:0]   start_reg, stop_reg, number_reg;
    logic          final_reg;
    logic          sub_reg;
    logic [31:0]   frag_cnt_reg;

    logic          load, take, last_of_entry;
    region_t       rec;
    logic [CMP_BITS-1:0] start_w, ovl_w, start_adj;

    assign load          = !out_valid_reg || regions.ready;
    assign take          = pop_valid && load;
    assign last_of_entry = sub_reg || !pop_entry.two;
    assign pop_ready     = load && last_of_entry;
    assign rec           = sub_reg ? pop_entry.second : pop_entry.first;

    // abutting region starts earlier by the overlap, floored at zero
    always_comb
    begin
        start_w   = pos_wide(rec.start_pos);
        ovl_w     = cfg_wide(overlap_length);
        start_adj = start_w;
        if (rec.abut)
        begin
            start_adj = (start_w >= ovl_w) ? (start_w - ovl_w) : '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            start_reg  <= wide_to_out(start_adj);
            stop_reg   <= wide_to_out(pos_wide(rec.stop_pos));
            number_reg <= frag_cnt_reg;
            final_reg  <= last_of_entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            sub_reg       <= 1'b0;
            frag_cnt_reg  <= '0;
        end
        else
        begin
            if (load)
            begin
                out_valid_reg <= pop_valid;
            end
            if (take)
            begin
                sub_reg      <= !last_of_entry;
                frag_cnt_reg <= frag_cnt_reg + 32'd1;
            end
        end
    end

    assign regions.valid           = out_valid_reg;
    assign regions.region_start    = start_reg;
    assign regions.region_end      = stop_reg;
    assign regions.fragment_number = number_reg;
    assign regions.final_of_item   = final_reg;

endmodule

// File: sv/sequence_fragmenter.sv
// sequence_fragmenter: top level; configuration registers, front scanner, queue, back end
// depends on sfrag_pkg, sfrag_if, sfrag_front, sfrag_queue, sfrag_back
//
//   channel   dir  handshake      word
//   bases     in   valid/ready    base_char[7:0], last_base
//   regions   out  valid/ready    region_start, region_end, fragment_number, final_of_item
//   cfg       in   cfg_we only    cfg_index[1:0], cfg_data[31:0]
//
// one base word is taken per cycle while the queue has room; the front scan updates its state in that cycle
// a base word may cause two region words; the back end sends one per cycle while
// regions.ready is high, so such a word holds the back end and the two-entry queue absorbs it
// a base word's region words are registered in the queue, then in the back end output register
// rst_n clears scan state, queue and fragment count; settings return to defaults
// a stalled regions side fills the queue, after which bases.ready drops
module sequence_fragmenter
    import sfrag_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    sfrag_base_if.sink          bases,
    sfrag_region_if.source      regions,
    input  logic                cfg_we,
    input  logic [IDX_BITS-1:0] cfg_index,
    input  logic [CFG_BITS-1:0] cfg_data
);

    logic [CFG_BITS-1:0]   piece_reg;
    logic [CFG_BITS-1:0]   overlap_reg;
    logic [LIMIT_BITS-1:0] limit_reg;

    logic     push_valid, push_ready;
    q_entry_t push_entry;
    logic     pop_valid, pop_ready;
    q_entry_t pop_entry;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            piece_reg   <= PIECE_RESET;
            overlap_reg <= OVERLAP_RESET;
            limit_reg   <= LIMIT_RESET;
        end
        else if (cfg_we)
        begin
            case (reg_index_t'(cfg_index))
                REG_PIECE_LENGTH:   piece_reg   <= cfg_data;
                REG_OVERLAP_LENGTH: overlap_reg <= cfg_data;
                REG_N_RUN_LIMIT:    limit_reg   <= cfg_data[LIMIT_BITS-1:0];
                default:            ;
            endcase
        end
    end

    sfrag_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .bases        (bases),
        .piece_length (piece_reg),
        .n_run_limit  (limit_reg),
        .push_valid   (push_valid),
        .push_ready   (push_ready),
        .push_entry   (push_entry)
    );

    sfrag_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_entry (push_entry),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_entry  (pop_entry)
    );

    sfrag_back u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .pop_valid      (pop_valid),
        .pop_ready      (pop_ready),
        .pop_entry      (pop_entry),
        .overlap_length (overlap_reg),
        .regions        (regions)
    );

endmodule

// File: sim/tb.sv
`timescale 1ns / 100ps
// tb: self-checking bench for sequence_fragmenter; directed table, then random sequences
// depends on sfrag_pkg, sfrag_if and the sequence_fragmenter rtl
module tb;
    import sfrag_pkg::*;

    localparam int HOLD_CYCLES    = 300;
    localparam int DRAIN_CYCLES   = 8;
    localparam int WATCHDOG_LIMIT = 3000;

    typedef enum bit {ROW_BASE, ROW_CFG} row_kind_t;
    typedef enum int {PACE_FULL, PACE_SENDER, PACE_RECEIVER, PACE_BOTH} pace_t;

    typedef struct packed {
        row_kind_t   kind;
        reg_index_t  idx;
        logic [31:0] value;
        logic        last;
        bit          typed;
        logic [31:0] exp_start;
        logic [31:0] exp_end;
        logic [31:0] exp_frag;
    } directed_row_t;

    typedef struct packed {
        logic [31:0] region_start;
        logic [31:0] region_end;
        logic [31:0] fragment_number;
        logic        final_of_item;
    } region_word_t;

    localparam logic [7:0] GOOD_BASES [8] = '{"A", "C", "G", "T", "a", "c", "g", "t"};

    // base rows carry an expected region only where it is plain to see
    localparam directed_row_t DIRECTED [32] = '{
        '{ROW_BASE, REG_PIECE_LENGTH, 32'(CHAR_N_UPPER), 1'b0, 1'b0, 32'd0, 32'd0, 32'd0},
        '{ROW_BASE, REG_PIECE_LENGTH, 32'("A"), 1'b0, 1'b0, 32'd0, 32'd0, 32'd0},
        '{ROW_BASE, REG_PIECE_LENGTH, 32'("c"), 1'b0, 1'b0, 32'd0, 32'd0, 32'd0},
        '{ROW_BASE, REG_PIECE_LENGTH, 32'(CHAR_N_LOWER), 1'b1, 1'b1, 32'd1, 32'd4, 32'd0},
        '{ROW_CFG, REG_PIECE_LENGTH, 32'd2, 1'b0, 1'b0, 32'd0, 32'd0, 32'd0},
        '{ROW_CFG, REG_OVERLAP_LENGTH, 32'd1, 1'b0, 1'b0, 32'd0, 32'd0, 32'd0},
        '{ROW_CFG, REG_N_RUN_LIMIT, 32'd0, 1'b0, 1'b0, 32'd0, 32'd0, 32'd0},
        '{ROW_BASE, REG_PIECE_LENGTH, 32'h00, 1'b0, 1'b0, 32'd0, 32'd0, 32'd0},
        '{ROW_BASE, REG_PIECE_LENGTH, 32'("A"), 1'b0, 1'b0, 32'd0, 32'd0, 32'd0},
        '{ROW_BASE, REG_PIECE_LENGTH, 32'("G"), 1'b0, 1'b0, 32'd0, 32'd0, 32'd0},
        '{ROW_BASE, REG_PIECE_LENGTH, 32'(CHAR_N_UPPER), 1'b0, 1'b0, 32'd0, 32'd0, 32'd0},
        '{ROW_BASE, REG_PIECE_LENGTH, 32'("T"), 1'b0, 1'b0, 32'd0, 32'd0, 32'd0},
        '{ROW_BASE, REG_PIECE_LENGTH, 32'("A"), 1'b0, 1'b0, 32'd0, 32'd0, 32'd0},
        '{ROW_BASE, REG_PIECE_LENGTH, 32'(CHAR_N_UPPER), 1'b0, 1'b0, 32'd0, 32'd0, 32'd0},
        '{ROW_BASE, REG_PIECE_LENGTH, 32'hFF, 1'b1, 1'b1, 32'd7, 32'd8, 32'd4},
        '{ROW_BASE, REG_PIECE_LENGTH, 32'("C"), 1'b0, 1'b0, 32'd0, 32'd0, 32'd0},
        '{ROW_BASE, REG_PIECE_LENGTH, 32'("G"), 1'b0, 1'b0, 32'd0, 32'd0, 32'd0},
        '{ROW_BASE, REG_PIECE_LENGTH, 32'("T"), 1'b1, 1'b0, 32'd0, 32'd0, 32'd0},
        '{ROW_CFG, REG_PIECE_LENGTH, 32'd0, 1'b0, 1'b0, 32'd0, 32'd0, 32'd0},
        '{ROW_CFG, REG_OVERLAP_LENGTH, 32'hFFFF_FFFF, 1'b0, 1'b0, 32'd0, 32'd0, 32'd0},
        '{ROW_CFG, REG_N_RUN_LIMIT, 32'hA5A5_FFFF, 1'b0, 1'b0, 32'd0, 32'd0, 32'd0},
        '{ROW_BASE, REG_PIECE_LENGTH, 32'("a"), 1'b0, 1'b0, 32'd0, 32'd0, 32'd0},
        '{ROW_BASE, REG_PIECE_LENGTH, 32'("b"), 1'b0, 1'b0, 32'd0, 32'd0, 32'd0},
        '{ROW_BASE, REG_PIECE_LENGTH, 32'(CHAR_N_LOWER), 1'b1, 1'b0, 32'd0, 32'd0, 32'd0},
        '{ROW_CFG, REG_PIECE_LENGTH, 32'hFFFF_FFFF, 1'b0, 1'b0, 32'd0, 32'd0, 32'd0},
        '{ROW_CFG, REG_OVERLAP_LENGTH, 32'd0, 1'b0, 1'b0, 32'd0, 32'd0, 32'd0},
        '{ROW_CFG, REG_N_RUN_LIMIT, 32'd2, 1'b0, 1'b0, 32'd0, 32'd0, 32'd0},
        '{ROW_BASE, REG_PIECE_LENGTH, 32'("A"), 1'b0, 1'b0, 32'd0, 32'd0, 32'd0},
        '{ROW_BASE, REG_PIECE_LENGTH, 32'(CHAR_N_UPPER), 1'b0, 1'b0, 32'd0, 32'd0, 32'd0},
        '{ROW_BASE, REG_PIECE_LENGTH, 32'(CHAR_N_UPPER), 1'b0, 1'b1, 32'd0, 32'd1, 32'd9},
        '{ROW_BASE, REG_PIECE_LENGTH, 32'(CHAR_N_UPPER), 1'b1, 1'b0, 32'd0, 32'd0, 32'd0},
        '{ROW_BASE, REG_PIECE_LENGTH, 32'(CHAR_N_LOWER), 1'b1, 1'b0, 32'd0, 32'd0, 32'd0}
    };

    logic                clk = 1'b0;
    logic                rst_n;
    logic                cfg_we;
    logic [IDX_BITS-1:0] cfg_index;
    logic [CFG_BITS-1:0] cfg_data;

    sfrag_base_if   base_ch ();
    sfrag_region_if region_ch ();

    sequence_fragmenter u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .bases     (base_ch),
        .regions   (region_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // fragmenter shadow: settings and scan state
    logic [31:0]         piece_len;
    logic [31:0]         overlap_len;
    logic [15:0]         run_limit;
    bit                  in_region;
    bit                  have_prev;
    logic [POS_BITS-1:0] position;
    logic [POS_BITS-1:0] open_start;
    logic [POS_BITS-1:0] last_good_end;
    logic [POS_BITS-1:0] prev_end;
    logic [15:0]         n_run;
    logic [31:0]         frag_count;

    region_word_t step_regions [$];
    region_word_t pending_regions [$];

    pace_t pace = PACE_FULL;
    int    hold_requests = 0;
    int    errors = 0;
    int    words_sent = 0;
    int    regions_checked = 0;
    int    reg_writes = 0;
    int    quiet_cycles = 0;

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    function automatic void close_region(input logic [POS_BITS-1:0] from_pos,
                                         input logic [POS_BITS-1:0] to_pos);
        longint unsigned s;
        region_word_t    w;
        s = longint'(from_pos);
        // abutting region pulled back by the overlap, floored at zero
        if (have_prev && prev_end == from_pos)
            s = (s >= longint'(overlap_len)) ? s - longint'(overlap_len) : 0;
        w.region_start    = 32'(s);
        w.region_end      = 32'(to_pos);
        w.fragment_number = frag_count;
        w.final_of_item   = 1'b0;
        step_regions.push_back(w);
        frag_count = frag_count + 32'd1;
        prev_end   = to_pos;
        have_prev  = 1'b1;
    endfunction

    function automatic void predict_regions(input logic [7:0] ch, input logic last);
        bit                  is_n;
        longint unsigned     len;
        longint unsigned     lim;
        logic [POS_BITS-1:0] span;
        is_n = (ch == CHAR_N_UPPER) || (ch == CHAR_N_LOWER);
        len  = (piece_len == 0) ? 1 : longint'(piece_len);
        lim  = (run_limit == 0) ? 1 : longint'(run_limit);
        span = position - open_start;
        step_regions.delete();

        // a full region is closed by the word after it, trimmed if that word is N
        if (in_region && longint'(span) >= len)
        begin
            close_region(open_start, is_n ? last_good_end : position);
            in_region = 1'b0;
        end
        if (!in_region && !is_n)
        begin
            in_region  = 1'b1;
            open_start = position;
            n_run      = '0;
        end
        if (in_region)
        begin
            if (is_n)
            begin
                if (n_run != LIMIT_MAX)
                    n_run = n_run + 16'd1;
                if (longint'(n_run) >= lim)
                begin
                    close_region(open_start, last_good_end);
                    in_region = 1'b0;
                end
            end
            else
            begin
                n_run         = '0;
                last_good_end = position + POS_ONE;
            end
        end
        if (last)
        begin
            if (in_region)
                close_region(open_start, position + POS_ONE);
            in_region = 1'b0;
            position  = '0;
            n_run     = '0;
            have_prev = 1'b0;
            prev_end  = '0;
        end
        else
            position = position + POS_ONE;

        if (step_regions.size() > 0)
            step_regions[step_regions.size() - 1].final_of_item = 1'b1;
    endfunction

    task automatic send_word(input logic [7:0] ch, input logic last, input bit typed,
                             input region_word_t typed_word);
        while ((pace == PACE_SENDER && $urandom_range(0, 99) < 61) ||
               (pace == PACE_BOTH && $urandom_range(0, 99) < 18))
        begin
            base_ch.valid <= 1'b0;
            @(posedge clk);
        end
        base_ch.valid     <= 1'b1;
        base_ch.base_char <= ch;
        base_ch.last_base <= last;
        do
            @(posedge clk);
        while (base_ch.ready !== 1'b1);
        words_sent++;
        predict_regions(ch, last);
        if (typed)
            pending_regions.push_back(typed_word);
        else
            foreach (step_regions[i])
                pending_regions.push_back(step_regions[i]);
    endtask

    // sender pauses until every region word is back and the pipeline is empty
    task automatic settle();
        base_ch.valid <= 1'b0;
        while (pending_regions.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input reg_index_t idx, input logic [31:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
        reg_writes++;
        case (idx)
            REG_PIECE_LENGTH:   piece_len   = data;
            REG_OVERLAP_LENGTH: overlap_len = data;
            REG_N_RUN_LIMIT:    run_limit   = data[15:0];
            default: ;
        endcase
    endtask

    task automatic send_sequence(input int unsigned len);
        int unsigned i;
        int unsigned run;
        int unsigned style;
        int unsigned kind;
        int unsigned n_cap;
        logic [7:0]  ch;
        i     = 0;
        style = $urandom_range(0, 99);
        n_cap = (run_limit == 0) ? 2 : ((run_limit < 8) ? run_limit + 1 : 8);
        while (i < len)
        begin
            kind = $urandom_range(0, 99);
            if (style < 10)
                kind = 95;
            else if (style < 15)
                kind = 70;
            if (kind < 60)
                run = $urandom_range(1, 6);
            else if (kind < 90)
                run = $urandom_range(1, n_cap);
            else
                run = 1;
            repeat (run)
            begin
                if (i < len)
                begin
                    if (kind < 60)
                        ch = GOOD_BASES[$urandom_range(0, 7)];
                    else if (kind < 90)
                        ch = $urandom_range(0, 1) ? CHAR_N_LOWER : CHAR_N_UPPER;
                    else
                        ch = 8'($urandom_range(0, 255));
                    send_word(ch, i == len - 1, 1'b0, '0);
                    i++;
                end
            end
        end
    endtask

    task automatic run_setting(input logic [31:0] piece, input logic [31:0] overlap,
                               input logic [31:0] limit, input pace_t mode,
                               input int unsigned items, input bit long_hold);
        int unsigned sent;
        int unsigned len;
        settle();
        write_reg(REG_PIECE_LENGTH, piece);
        write_reg(REG_OVERLAP_LENGTH, overlap);
        write_reg(REG_N_RUN_LIMIT, limit);
        pace = mode;
        if (long_hold)
            hold_requests++;
        sent = 0;
        while (sent < items)
        begin
            len = ($urandom_range(0, 9) == 0) ? 1 : $urandom_range(2, 24);
            send_sequence(len);
            sent += len;
        end
    endtask

    // region side: compare accepted words, then choose ready for the next edge
    initial
    begin
        int           hold_left;
        int           hold_seen;
        region_word_t want;
        hold_left = 0;
        hold_seen = 0;
        region_ch.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (region_ch.valid && region_ch.ready)
            begin
                regions_checked++;
                if (pending_regions.size() == 0)
                begin
                    $error("unexpected region word: start %0d end %0d fragment %0d",
                           region_ch.region_start, region_ch.region_end,
                           region_ch.fragment_number);
                    errors++;
                end
                else
                begin
                    want = pending_regions.pop_front();
                    if (region_ch.region_start !== want.region_start)
                    begin
                        $error("region_start: expected %0d, got %0d",
                               want.region_start, region_ch.region_start);
                        errors++;
                    end
                    if (region_ch.region_end !== want.region_end)
                    begin
                        $error("region_end: expected %0d, got %0d",
                               want.region_end, region_ch.region_end);
                        errors++;
                    end
                    if (region_ch.fragment_number !== want.fragment_number)
                    begin
                        $error("fragment_number: expected %0d, got %0d",
                               want.fragment_number, region_ch.fragment_number);
                        errors++;
                    end
                    if (region_ch.final_of_item !== want.final_of_item)
                    begin
                        $error("final_of_item: expected %0d, got %0d",
                               want.final_of_item, region_ch.final_of_item);
                        errors++;
                    end
                end
            end
            if (hold_left > 0)
            begin
                region_ch.ready <= 1'b0;
                hold_left--;
            end
            else if (hold_seen != hold_requests)
            begin
                hold_seen       = hold_requests;
                hold_left       = HOLD_CYCLES;
                region_ch.ready <= 1'b0;
            end
            else
                region_ch.ready <= !((pace == PACE_RECEIVER && $urandom_range(0, 99) < 61) ||
                                     (pace == PACE_BOTH && $urandom_range(0, 99) < 18));
        end
    end

    always @(posedge clk)
    begin
        if ((base_ch.valid && base_ch.ready) || (region_ch.valid && region_ch.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("watchdog: no word moved for %0d cycles", quiet_cycles);
            $display("Test completed with failures");
            $finish;
        end
    end

    initial
    begin
        region_word_t tw;
        rst_n             = 1'b0;
        cfg_we            = 1'b0;
        cfg_index         = REG_PIECE_LENGTH;
        cfg_data          = '0;
        base_ch.valid     = 1'b0;
        base_ch.base_char = '0;
        base_ch.last_base = 1'b0;
        piece_len     = PIECE_RESET;
        overlap_len   = OVERLAP_RESET;
        run_limit     = LIMIT_RESET;
        in_region     = 1'b0;
        have_prev     = 1'b0;
        position      = '0;
        open_start    = '0;
        last_good_end = '0;
        prev_end      = '0;
        n_run         = '0;
        frag_count    = '0;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (DIRECTED[r])
        begin
            if (DIRECTED[r].kind == ROW_CFG)
            begin
                if (r > 0 && DIRECTED[r - 1].kind == ROW_BASE)
                    settle();
                write_reg(DIRECTED[r].idx, DIRECTED[r].value);
            end
            else
            begin
                tw = '{DIRECTED[r].exp_start, DIRECTED[r].exp_end,
                       DIRECTED[r].exp_frag, 1'b1};
                send_word(DIRECTED[r].value[7:0], DIRECTED[r].last, DIRECTED[r].typed, tw);
            end
        end

        // random part: mostly small lengths keep regions frequent
        run_setting(32'd4, 32'd0, 32'd3, PACE_FULL, 60, 1'b0);
        run_setting(32'd7, 32'd2, 32'd5, PACE_SENDER, 60, 1'b0);
        run_setting(32'd3, 32'd1, 32'd1, PACE_RECEIVER, 60, 1'b1);
        run_setting(32'd5, 32'd3, 32'd2, PACE_BOTH, 60, 1'b0);
        run_setting(32'd1, 32'hFFFF_FFFF, 32'd2, PACE_FULL, 50, 1'b1);
        run_setting(32'hFFFF_FFFF, 32'd0, 32'h0000_FFFF, PACE_SENDER, 40, 1'b0);
        run_setting(32'd0, 32'd1, 32'd0, PACE_RECEIVER, 50, 1'b0);
        run_setting($urandom_range(1, 12), $urandom_range(0, 6), $urandom_range(1, 6),
                    PACE_BOTH, 60, 1'b0);
        run_setting(32'd1024, 32'd0, 32'd50, PACE_FULL, 60, 1'b0);
        settle();

        $display("covered %0d base words under %0d register writes", words_sent, reg_writes);
        $display("compared %0d region words, %0d mismatches", regions_checked, errors);
        if (errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

// File: sim.f
sv/sfrag_pkg.sv
sv/sfrag_if.sv
sv/sfrag_front.sv
sv/sfrag_queue.sv
sv/sfrag_back.sv
sv/sequence_fragmenter.sv
sim/tb.sv
